[hdl/biq_pkg.sv]
// Package with the widths, register indexes and configuration type of the biquad filter.
package biq_pkg;

    localparam int SAMPLE_WIDTH = 24;
    localparam int COEF_WIDTH   = 32;
    localparam int COEF_FRAC    = COEF_WIDTH - 8;
    localparam int MID_WIDTH    = 32;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = (MID_WIDTH > SAMPLE_WIDTH) ? MID_WIDTH : SAMPLE_WIDTH;
    localparam int PROD_W  = MUL_A_W + COEF_WIDTH;

    // Five exact products of sample by coefficient need three guard bits.
    localparam int ACC_W = SAMPLE_WIDTH + COEF_WIDTH + 3;

    localparam int REG_COUNT  = 7;
    localparam int CFG_IDX_W  = $clog2(REG_COUNT);
    localparam int CFG_DATA_W = COEF_WIDTH;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_A1     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_A2     = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_B0     = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_B1     = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_B2     = CFG_IDX_W'(6);

    localparam logic [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1) << COEF_FRAC;

    typedef struct packed {
        logic                          filter_enable;
        logic signed [COEF_WIDTH-1:0]  norm_gain;
        logic signed [COEF_WIDTH-1:0]  fb_coef_1;
        logic signed [COEF_WIDTH-1:0]  fb_coef_2;
        logic signed [COEF_WIDTH-1:0]  ff_coef_0;
        logic signed [COEF_WIDTH-1:0]  ff_coef_1;
        logic signed [COEF_WIDTH-1:0]  ff_coef_2;
    } t_cfg;

endpackage

[hdl/biq_if.sv]
// Stream interfaces for the input and result samples of the biquad filter.
interface biq_in_if
    import biq_pkg::*;
;
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface biq_out_if
    import biq_pkg::*;
;
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

[hdl/biquad_iir_filter.sv]
// Top level of the direct form I biquad filter with a shared multiplier.
//
//  Channel   Direction  Payload                Handshake
//  i_in      sink       sample_in  (24 bits)   valid/ready
//  o_out     source     sample_out (24 bits)   valid/ready
//  i_cfg_*   write      i_cfg_data (32 bits)   i_cfg_we, no wait
//
// A filtered sample passes from acceptance to the output register through five
// multiply-accumulate steps, each a multiply state and an accumulate state on the one
// multiplier, then rounding, the gain product, the final rounding and a hand-over state.
// A bypassed sample goes straight to the hand-over state. Input is taken only while the
// sequencer is idle, so a new sample waits until the last has been handed over. A result waiting on o_out
// holds the next finished sample in the hand-over state, which keeps the input blocked.
// Reset is synchronous and clears the history and the configuration.
module biquad_iir_filter
    import biq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    biq_in_if.sink                i_in,
    biq_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_ACC  = 7'b0000100,
        S_RND  = 7'b0001000,
        S_GMUL = 7'b0010000,
        S_GRND = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    localparam logic [2:0] STEP_B0 = 3'd0;
    localparam logic [2:0] STEP_B1 = 3'd1;
    localparam logic [2:0] STEP_B2 = 3'd2;
    localparam logic [2:0] STEP_A1 = 3'd3;
    localparam logic [2:0] STEP_A2 = 3'd4;

    localparam int RW1 = (ACC_W + 1 > MID_WIDTH + 1) ? ACC_W + 1 : MID_WIDTH + 1;
    localparam int RW2 = PROD_W + 1;

    localparam logic signed [RW1-1:0] ACC_HALF = RW1'(1) << (COEF_FRAC - 1);
    localparam logic signed [RW1-1:0] MID_HI   = RW1'({(MID_WIDTH-1){1'b1}});
    localparam logic signed [RW1-1:0] MID_LO   = ~MID_HI;
    localparam logic signed [RW2-1:0] PRD_HALF = RW2'(1) << (COEF_FRAC - 1);
    localparam logic signed [RW2-1:0] OUT_HI   = RW2'({(SAMPLE_WIDTH-1){1'b1}});
    localparam logic signed [RW2-1:0] OUT_LO   = ~OUT_HI;

    t_cfg w_cfg;

    t_state r_state, n_state;
    logic [2:0] r_step;
    logic r_filt;
    logic signed [SAMPLE_WIDTH-1:0] r_x, r_x1, r_x2, r_y1, r_y2, r_y;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [MID_WIDTH-1:0] r_mid;
    logic r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_data;

    logic signed [MUL_A_W-1:0]    w_a;
    logic signed [COEF_WIDTH-1:0] w_b;
    logic signed [PROD_W-1:0]     w_prod;
    logic signed [ACC_W-1:0]      w_term;
    logic signed [RW1-1:0]        w_acc_sh;
    logic signed [MID_WIDTH-1:0]  w_mid;
    logic signed [RW2-1:0]        w_prd_sh;
    logic signed [SAMPLE_WIDTH-1:0] w_y;
    logic w_in_acc, w_load;

    biq_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    biq_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_prod (w_prod)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_load     = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    // Operand selection for the shared multiplier.
    always_comb begin
        w_a = MUL_A_W'(r_x);
        w_b = w_cfg.ff_coef_0;
        if (r_state == S_GMUL) begin
            w_a = MUL_A_W'(r_mid);
            w_b = w_cfg.norm_gain;
        end else begin
            case (r_step)
                STEP_B0: begin
                    w_a = MUL_A_W'(r_x);
                    w_b = w_cfg.ff_coef_0;
                end
                STEP_B1: begin
                    w_a = MUL_A_W'(r_x1);
                    w_b = w_cfg.ff_coef_1;
                end
                STEP_B2: begin
                    w_a = MUL_A_W'(r_x2);
                    w_b = w_cfg.ff_coef_2;
                end
                STEP_A1: begin
                    w_a = MUL_A_W'(r_y1);
                    w_b = w_cfg.fb_coef_1;
                end
                STEP_A2: begin
                    w_a = MUL_A_W'(r_y2);
                    w_b = w_cfg.fb_coef_2;
                end
                default: begin
                    w_a = MUL_A_W'(r_x);
                    w_b = w_cfg.ff_coef_0;
                end
            endcase
        end
    end

    assign w_term = ACC_W'(w_prod);

    // Round half up, then saturate the sum to the intermediate width.
    always_comb begin
        w_acc_sh = (RW1'(r_acc) + ACC_HALF) >>> COEF_FRAC;
        if (w_acc_sh > MID_HI) begin
            w_mid = MID_WIDTH'(MID_HI);
        end else if (w_acc_sh < MID_LO) begin
            w_mid = MID_WIDTH'(MID_LO);
        end else begin
            w_mid = MID_WIDTH'(w_acc_sh);
        end
    end

    // Same rounding on the gain product, saturating to the sample width.
    always_comb begin
        w_prd_sh = (RW2'(w_prod) + PRD_HALF) >>> COEF_FRAC;
        if (w_prd_sh > OUT_HI) begin
            w_y = SAMPLE_WIDTH'(OUT_HI);
        end else if (w_prd_sh < OUT_LO) begin
            w_y = SAMPLE_WIDTH'(OUT_LO);
        end else begin
            w_y = SAMPLE_WIDTH'(w_prd_sh);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_cfg.filter_enable ? S_MUL : S_DONE;
                end
            end
            S_MUL:  n_state = S_ACC;
            S_ACC:  n_state = (r_step == STEP_A2) ? S_RND : S_MUL;
            S_RND:  n_state = S_GMUL;
            S_GMUL: n_state = S_GRND;
            S_GRND: n_state = S_DONE;
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= STEP_B0;
            r_filt      <= 1'b0;
            r_out_valid <= 1'b0;
            r_x1        <= '0;
            r_x2        <= '0;
            r_y1        <= '0;
            r_y2        <= '0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_step <= STEP_B0;
                r_filt <= w_cfg.filter_enable;
            end else if (r_state == S_ACC && r_step != STEP_A2) begin
                r_step <= r_step + 3'd1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
                if (r_filt) begin
                    r_x1 <= r_x;
                    r_x2 <= r_x1;
                    r_y1 <= r_y;
                    r_y2 <= r_y1;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_x   <= i_in.sample_in;
            r_y   <= i_in.sample_in;
            r_acc <= '0;
        end
        if (r_state == S_ACC) begin
            if (r_step == STEP_A1 || r_step == STEP_A2) begin
                r_acc <= r_acc - w_term;
            end else begin
                r_acc <= r_acc + w_term;
            end
        end
        if (r_state == S_RND) begin
            r_mid <= w_mid;
        end
        if (r_state == S_GRND) begin
            r_y <= w_y;
        end
        if (w_load) begin
            r_out_data <= r_y;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_data;

endmodule

[hdl/biq_cfg.sv]
// Configuration register file holding the enable, gain and coefficients.
module biq_cfg
    import biq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_enable <= 1'b0;
            r_cfg.norm_gain     <= COEF_ONE;
            r_cfg.fb_coef_1     <= '0;
            r_cfg.fb_coef_2     <= '0;
            r_cfg.ff_coef_0     <= COEF_ONE;
            r_cfg.ff_coef_1     <= '0;
            r_cfg.ff_coef_2     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ENABLE: r_cfg.filter_enable <= i_cfg_data[0];
                REG_GAIN:   r_cfg.norm_gain     <= i_cfg_data[COEF_WIDTH-1:0];
                REG_A1:     r_cfg.fb_coef_1     <= i_cfg_data[COEF_WIDTH-1:0];
                REG_A2:     r_cfg.fb_coef_2     <= i_cfg_data[COEF_WIDTH-1:0];
                REG_B0:     r_cfg.ff_coef_0     <= i_cfg_data[COEF_WIDTH-1:0];
                REG_B1:     r_cfg.ff_coef_1     <= i_cfg_data[COEF_WIDTH-1:0];
                REG_B2:     r_cfg.ff_coef_2     <= i_cfg_data[COEF_WIDTH-1:0];
                default: begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hdl/biq_mul.sv]
// Shared signed multiplier with a registered product.
module biq_mul
    import biq_pkg::*;
(
    input  logic                         i_clk,
    input  logic signed [MUL_A_W-1:0]    i_a,
    input  logic signed [COEF_WIDTH-1:0] i_b,
    output logic signed [PROD_W-1:0]     o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

[hdl/biq_checker.sv]
// Port-level checker for the biquad filter and the bind that attaches it.
module biq_checker
    import biq_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic [SAMPLE_WIDTH-1:0] i_out_data
);

    // One sample at a time: the sequencer leaves idle once a beat is taken.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready stayed high after an accepted beat");

    // A fresh result is only ever loaded while the sequencer is busy.
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without a sample in progress");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result changed or was dropped");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind biquad_iir_filter biq_checker u_biq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.sample_out)
);
